// ===== src/dqrs_pkg.sv =====
`timescale 1ns / 1ps

package dqrs_pkg;

    // loop mode codes
    localparam logic [1:0] LOOP_VOLTAGE = 2'd0;
    localparam logic [1:0] LOOP_CURRENT = 2'd1;
    localparam logic [1:0] LOOP_TORQUE  = 2'd2;
    localparam logic [1:0] LOOP_SPEED   = 2'd3;

    // field weakening modes that change the selection
    localparam logic [2:0] WEAK_ZERO_ID   = 3'd2;
    localparam logic [2:0] WEAK_RAMP_A    = 3'd3;
    localparam logic [2:0] WEAK_RAMP_B    = 3'd4;

    // register indexes of the config port
    localparam logic [2:0] REG_RUN_LOOP_MODE = 3'd0;
    localparam logic [2:0] REG_FW_MODE       = 3'd1;
    localparam logic [2:0] REG_MTPA_ENABLE   = 3'd2;
    localparam logic [2:0] REG_MTPA_CURRENT  = 3'd3;
    localparam logic [2:0] REG_MTPA_ANGLE    = 3'd4;
    localparam logic [2:0] REG_ID_MANUAL     = 3'd5;
    localparam logic [2:0] REG_IQ_MANUAL     = 3'd6;
    localparam logic [2:0] REG_CURRENT_STEP  = 3'd7;

    // angle limits and reset
    localparam logic [7:0] ANGLE_LIMIT = 8'd90;
    localparam logic [6:0] ANGLE_MAX   = 7'd90;
    localparam logic [7:0] ANGLE_RESET = 8'd15;
    localparam int         SIN_ENTRIES = 91;

    // pi in Q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // d/q pair of current values, held within the current width range
    typedef struct packed {
        logic signed [31:0] id;
        logic signed [31:0] iq;
    } dq_pair_t;

    // clamp a 32-bit value to the signed range of cw bits
    function automatic logic signed [31:0] sat_cur(input logic signed [31:0] v, input int cw);
        longint hi;
        longint lo;
        longint vl;
        logic signed [31:0] r;
        hi = (longint'(1) << (cw - 1)) - 1;
        lo = -hi - 1;
        vl = longint'(v);
        if (vl > hi)
        begin
            r = 32'(hi);
        end
        else if (vl < lo)
        begin
            r = 32'(lo);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // sin(deg degrees) by Taylor series in Q30, rounded half up to Q(frac)
    function automatic longint unsigned sin_entry(input int deg, input int frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x = (longint'(deg) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x) >> 30;
        // twenty alternating terms x^k / k!, each built from the one before
        term = x;
        sum = longint'(term);
        term = ((term * x2) >> 30) / 64'd6;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd420;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd506;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd600;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd702;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd812;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd930;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd1056;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd1190;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd1332;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd1482;
        sum = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        return (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

// ===== src/dqrs_mtpa_target.sv =====
`timescale 1ns / 1ps

module dqrs_mtpa_target #(
    parameter int FRAC_BITS     = 15,
    parameter int CURRENT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [31:0]  mtpa_current,
    input  logic [7:0]          mtpa_angle,
    output dqrs_pkg::dq_pair_t  target
);

    localparam int PW = 33 + FRAC_BITS;

    // sine table, one entry per degree, 1.0 included
    logic [FRAC_BITS:0] sin_tab [0:dqrs_pkg::SIN_ENTRIES-1];

    genvar g;
    generate
        for (g = 0; g < dqrs_pkg::SIN_ENTRIES; g = g + 1)
        begin : g_sin
            localparam longint unsigned ENT = dqrs_pkg::sin_entry(g, FRAC_BITS);
            assign sin_tab[g] = ENT[FRAC_BITS:0];
        end
    endgenerate

    logic [6:0]           angle;
    logic [FRAC_BITS:0]   sin_val;
    logic [FRAC_BITS:0]   cos_val;
    logic [31:0]          mag;
    logic [PW-1:0]        prod_d_next;
    logic signed [PW-1:0] prod_q_next;
    logic [PW-1:0]        prod_d_reg;
    logic signed [PW-1:0] prod_q_reg;
    logic [PW-1:0]        quot_d;
    logic signed [PW-1:0] quot_q;
    logic signed [33:0]   tid_wide;
    dqrs_pkg::dq_pair_t   target_next;
    dqrs_pkg::dq_pair_t   target_reg;

    // clamp the angle and look up sine and cosine
    assign angle   = (mtpa_angle > dqrs_pkg::ANGLE_LIMIT) ? dqrs_pkg::ANGLE_MAX
                                                           : mtpa_angle[6:0];
    assign sin_val = sin_tab[angle];
    assign cos_val = sin_tab[7'(dqrs_pkg::ANGLE_MAX - angle)];

    // |Is| and the two exact products
    assign mag         = mtpa_current[31] ? 32'(-mtpa_current) : 32'(mtpa_current);
    assign prod_d_next = PW'(mag) * PW'(sin_val);
    assign prod_q_next = PW'(mtpa_current) * PW'($signed({1'b0, cos_val}));

    // products of the reset config are zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_d_reg <= '0;
            prod_q_reg <= '0;
        end
        else
        begin
            prod_d_reg <= prod_d_next;
            prod_q_reg <= prod_q_next;
        end
    end

    // scale back with floor, negate the d part, clamp to the current range
    assign quot_d   = prod_d_reg >> FRAC_BITS;
    assign quot_q   = prod_q_reg >>> FRAC_BITS;
    assign tid_wide = -$signed({1'b0, quot_d[32:0]});

    always_comb
    begin
        target_next.id = dqrs_pkg::sat_cur($signed(tid_wide[31:0]), CURRENT_WIDTH);
        target_next.iq = dqrs_pkg::sat_cur($signed(quot_q[31:0]), CURRENT_WIDTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    assign target = target_reg;

endmodule

// ===== src/dq_current_reference_selector.sv =====
`timescale 1ns / 1ps

// channel   | dir | handshake             | payload
// s_axis    | in  | tvalid / tready       | tdata: torque id, torque iq, speed id, speed iq
//           |     |                       | tuser: diag_bypass
// m_axis    | out | tvalid / tready       | tdata: id_command, iq_command
// cfg       | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle unless the output stalls or a config write holds off the inputs; each
// item passes the input register and the result register around the select and ramp logic
// rst_n clears the config registers (MTPA angle to 15), the held commands and all valid flags
// a stalled output keeps the result and the input register still takes one more item
// inputs are held off during a config write and the cycle after it, while the
// two-stage MTPA product path settles

module dq_current_reference_selector #(
    parameter int FRAC_BITS     = 15,
    parameter int CURRENT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // torque_id_ref, torque_iq_ref, speed_id_ref, speed_iq_ref
    input  logic [127:0]  s_axis_tdata,
    // diag_bypass
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // id_command, iq_command
    output logic [63:0]   m_axis_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int CW = CURRENT_WIDTH;

    // config registers
    logic [1:0]         run_loop_mode_reg;
    logic [2:0]         fw_mode_reg;
    logic               mtpa_enable_reg;
    logic signed [31:0] mtpa_current_reg;
    logic [7:0]         mtpa_angle_reg;
    logic signed [31:0] id_manual_reg;
    logic signed [31:0] iq_manual_reg;
    logic [30:0]        current_step_reg;
    logic               cfg_pending_reg;
    logic               cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_loop_mode_reg <= dqrs_pkg::LOOP_VOLTAGE;
            fw_mode_reg       <= '0;
            mtpa_enable_reg   <= 1'b0;
            mtpa_current_reg  <= '0;
            mtpa_angle_reg    <= dqrs_pkg::ANGLE_RESET;
            id_manual_reg     <= '0;
            iq_manual_reg     <= '0;
            current_step_reg  <= '0;
            cfg_pending_reg   <= 1'b0;
        end
        else
        begin
            cfg_pending_reg <= cfg_xfer;
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    dqrs_pkg::REG_RUN_LOOP_MODE: run_loop_mode_reg <= cfg_data[1:0];
                    dqrs_pkg::REG_FW_MODE:       fw_mode_reg       <= cfg_data[2:0];
                    dqrs_pkg::REG_MTPA_ENABLE:   mtpa_enable_reg   <= cfg_data[0];
                    dqrs_pkg::REG_MTPA_CURRENT:  mtpa_current_reg  <= $signed(cfg_data);
                    dqrs_pkg::REG_MTPA_ANGLE:    mtpa_angle_reg    <= cfg_data[7:0];
                    dqrs_pkg::REG_ID_MANUAL:     id_manual_reg     <= $signed(cfg_data);
                    dqrs_pkg::REG_IQ_MANUAL:     iq_manual_reg     <= $signed(cfg_data);
                    dqrs_pkg::REG_CURRENT_STEP:  current_step_reg  <= cfg_data[30:0];
                    default:                     current_step_reg  <= current_step_reg;
                endcase
            end
        end
    end

    // MTPA targets from the config registers
    dqrs_pkg::dq_pair_t mtpa_target;

    dqrs_mtpa_target #(
        .FRAC_BITS     (FRAC_BITS),
        .CURRENT_WIDTH (CURRENT_WIDTH)
    ) u_mtpa_target (
        .clk          (clk),
        .rst_n        (rst_n),
        .mtpa_current (mtpa_current_reg),
        .mtpa_angle   (mtpa_angle_reg),
        .target       (mtpa_target)
    );

    // input register
    logic               in_valid_reg;
    logic [127:0]       in_data_reg;
    logic               in_bypass_reg;
    logic               in_xfer;
    logic               advance;
    logic               out_valid_reg;
    logic signed [CW-1:0] id_held_reg;
    logic signed [CW-1:0] iq_held_reg;
    logic signed [CW-1:0] id_held_next;
    logic signed [CW-1:0] iq_held_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (!in_valid_reg || advance) && !cfg_valid && !cfg_pending_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg   <= s_axis_tdata;
            in_bypass_reg <= s_axis_tuser[0];
        end
    end

    // step toward a target, stopping at it
    function automatic logic signed [CW-1:0] ramp_to(
        input logic signed [CW-1:0] held,
        input logic signed [CW-1:0] target,
        input logic [30:0]          step
    );
        logic signed [33:0] h;
        logic signed [33:0] t;
        logic signed [33:0] s;
        logic signed [33:0] n;
        h = 34'(held);
        t = 34'(target);
        s = $signed({3'b000, step});
        if (t > h)
        begin
            n = h + s;
            if (n > t)
            begin
                n = t;
            end
        end
        else if (t < h)
        begin
            n = h - s;
            if (n < t)
            begin
                n = t;
            end
        end
        else
        begin
            n = t;
        end
        return n[CW-1:0];
    endfunction

    // clamped inputs and manual targets
    logic signed [CW-1:0] t_id;
    logic signed [CW-1:0] t_iq;
    logic signed [CW-1:0] s_id;
    logic signed [CW-1:0] s_iq;
    logic signed [CW-1:0] m_id;
    logic signed [CW-1:0] m_iq;
    logic signed [31:0]   t_id_sat;
    logic signed [31:0]   t_iq_sat;
    logic signed [31:0]   s_id_sat;
    logic signed [31:0]   s_iq_sat;
    logic signed [31:0]   m_id_sat;
    logic signed [31:0]   m_iq_sat;
    logic signed [31:0]   mtpa_id_w;
    logic signed [31:0]   mtpa_iq_w;

    assign t_id_sat  = dqrs_pkg::sat_cur($signed(in_data_reg[31:0]), CW);
    assign t_iq_sat  = dqrs_pkg::sat_cur($signed(in_data_reg[63:32]), CW);
    assign s_id_sat  = dqrs_pkg::sat_cur($signed(in_data_reg[95:64]), CW);
    assign s_iq_sat  = dqrs_pkg::sat_cur($signed(in_data_reg[127:96]), CW);
    assign m_id_sat  = dqrs_pkg::sat_cur(id_manual_reg, CW);
    assign m_iq_sat  = dqrs_pkg::sat_cur(iq_manual_reg, CW);
    assign mtpa_id_w = mtpa_target.id;
    assign mtpa_iq_w = mtpa_target.iq;
    assign t_id      = t_id_sat[CW-1:0];
    assign t_iq      = t_iq_sat[CW-1:0];
    assign s_id      = s_id_sat[CW-1:0];
    assign s_iq      = s_iq_sat[CW-1:0];
    assign m_id      = m_id_sat[CW-1:0];
    assign m_iq      = m_iq_sat[CW-1:0];

    // command selection per loop mode
    always_comb
    begin
        id_held_next = '0;
        iq_held_next = '0;
        unique case (run_loop_mode_reg)
            dqrs_pkg::LOOP_SPEED:
            begin
                priority if (in_bypass_reg)
                begin
                    id_held_next = s_id;
                    iq_held_next = s_iq;
                end
                else if (fw_mode_reg == dqrs_pkg::WEAK_ZERO_ID)
                begin
                    id_held_next = '0;
                    iq_held_next = s_iq;
                end
                else
                begin
                    id_held_next = t_id;
                    iq_held_next = t_iq;
                end
            end
            dqrs_pkg::LOOP_TORQUE:
            begin
                if (fw_mode_reg == dqrs_pkg::WEAK_RAMP_A)
                begin
                    id_held_next = '0;
                    iq_held_next = '0;
                end
                else
                begin
                    id_held_next = t_id;
                    iq_held_next = t_iq;
                end
            end
            dqrs_pkg::LOOP_CURRENT:
            begin
                priority if (mtpa_enable_reg)
                begin
                    id_held_next = ramp_to(id_held_reg, mtpa_id_w[CW-1:0], current_step_reg);
                    iq_held_next = ramp_to(iq_held_reg, mtpa_iq_w[CW-1:0], current_step_reg);
                end
                else if (fw_mode_reg == dqrs_pkg::WEAK_RAMP_A ||
                         fw_mode_reg == dqrs_pkg::WEAK_RAMP_B)
                begin
                    id_held_next = ramp_to(id_held_reg, m_id, current_step_reg);
                    iq_held_next = ramp_to(iq_held_reg, m_iq, current_step_reg);
                end
                else
                begin
                    id_held_next = m_id;
                    iq_held_next = m_iq;
                end
            end
            dqrs_pkg::LOOP_VOLTAGE:
            begin
                id_held_next = '0;
                iq_held_next = '0;
            end
            default:
            begin
                id_held_next = '0;
                iq_held_next = '0;
            end
        endcase
    end

    // result register, which is also the held command state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            id_held_reg   <= '0;
            iq_held_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                id_held_reg   <= id_held_next;
                iq_held_reg   <= iq_held_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {32'(iq_held_reg), 32'(id_held_reg)};

endmodule
